// ===== rtl/sdg_pkg.sv =====
// Shared types, constants and codes for the synthetic data generator.
`default_nettype none
package sdg_pkg;

	// Stream geometry
	localparam int BLOCK_BYTES = 65536;
	localparam int PATTERN_MAX = 8;
	localparam int BLK_WORDS   = BLOCK_BYTES / 8;
	localparam int WIDX_W      = $clog2(BLK_WORDS);
	localparam int WNUM_W      = 61;
	localparam int BLK_W       = WNUM_W - WIDX_W;

	// Mixing constants
	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;

	// Register indexes
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_SEED    = 2'd1;
	localparam logic [1:0] REG_PATTERN = 2'd2;
	localparam logic [1:0] REG_PLEN    = 2'd3;

	typedef enum logic [1:0] {
		MODE_PATTERN  = 2'd0,
		MODE_HASH     = 2'd1,
		MODE_XOSHIRO  = 2'd2,
		MODE_HASH_ALT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		MS_GOLD,
		MS_M1,
		MS_M2
	} mul_sel_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_LL,
		MP_LH,
		MP_HL
	} mul_ph_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_H_GOLD,
		ST_H_GW,
		ST_M1,
		ST_M1W,
		ST_M2,
		ST_M2W,
		ST_MSTORE,
		ST_S_NEXT,
		ST_G_CHECK,
		ST_G_ADV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [63:0] byte_offset;
		logic [3:0]  byte_count;
	} req_t;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  valid_bytes;
	} rsp_t;

	typedef struct packed {
		logic     load;
		logic     mod_step;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     z_from_prod_seed;
		logic     z_from_prod;
		logic     z_from_s;
		logic     seed_init;
		logic     mix_store;
		logic     gen_setup;
		logic     gen_step;
		logic     gen_take;
		logic     next_word;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic mode_pat;
		logic mode_xo;
		logic mul_done;
		logic mod_last;
		logic cache_hit;
		logic seed_last;
		logic at_target;
		logic need_second;
		logic out_full;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/sdg_mul.sv =====
// Iterative 64x64 multiplier, low 64 bits, one 32x32 partial product a cycle.
`default_nettype none
module sdg_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      p
);
	import sdg_pkg::*;

	mul_ph_t     ph_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	// Pick the partial product for this phase
	always_comb begin
		unique case (ph_q)
			MP_LH: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
			end
			MP_HL: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
			end
			default: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
			end
		endcase
		prod = 64'(op_a) * 64'(op_b);
	end

	// Advance phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= MP_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == MP_HL);
			unique case (ph_q)
				MP_IDLE: if (start) ph_q <= MP_LL;
				MP_LL:   ph_q <= MP_LH;
				MP_LH:   ph_q <= MP_HL;
				MP_HL:   ph_q <= MP_IDLE;
				default: ph_q <= MP_IDLE;
			endcase
		end
	end

	// Accumulate partial products
	always_ff @(posedge clk) begin
		if (start && ph_q == MP_IDLE) begin
			a_q <= a;
			b_q <= b;
		end
		unique case (ph_q)
			MP_LL:        acc_q <= prod;
			MP_LH, MP_HL: acc_q <= acc_q + {prod[31:0], 32'd0};
			default:      acc_q <= acc_q;
		endcase
	end

	assign done = done_q;
	assign p    = acc_q;

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) (ph_q != MP_IDLE) |-> !done_q || ph_q == MP_LL;
	endproperty
	a_no_restart: assert property (p_no_restart) else $error("mul done while busy");

	a_done_after_hl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ph_q) == MP_HL) else $error("mul done out of phase");

	a_ll_follows_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == MP_LL) |-> $past(ph_q) == MP_IDLE) else $error("mul phase skipped");

endmodule
`default_nettype wire

// ===== rtl/sdg_datapath.sv =====
// Datapath: request registers, modulo unit, hash mixer, xoshiro state and cache, output word.
`default_nettype none
module sdg_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sdg_pkg::cmd_t cmd,
	output sdg_pkg::sts_t      sts,
	input  wire sdg_pkg::req_t req,
	input  wire logic [1:0]    mode,
	input  wire logic [63:0]   seed,
	input  wire logic [63:0]   pattern_bytes,
	input  wire logic [3:0]    pattern_length,
	input  wire logic          cache_inval,
	output sdg_pkg::rsp_t      rsp,
	output logic               rsp_valid,
	input  wire logic          rsp_stall
);
	import sdg_pkg::*;

	logic [63:0]       off_q;
	logic [3:0]        cnt_q;
	logic [WNUM_W-1:0] wn_q;
	logic              slot_q;
	logic [63:0]       word0_q;
	logic [63:0]       word1_q;
	logic [63:0]       z_q;
	logic [63:0]       s_q;
	logic [1:0]        k_q;
	logic [63:0]       x_q [4];
	logic [BLK_W-1:0]  cblk_q;
	logic [WIDX_W-1:0] cidx_q;
	logic              cval_q;
	logic [WIDX_W-1:0] gcnt_q;
	logic [2:0]        rem_q;
	logic [4:0]        dig_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [3:0]        cnt_in;
	logic [3:0]        plen;
	logic [BLK_W-1:0]  blk;
	logic [WIDX_W-1:0] widx;
	logic              is_xo;
	logic [63:0]       mul_a;
	logic [63:0]       mul_b;
	logic              mul_done;
	logic [63:0]       mul_p;
	logic [63:0]       mix_res;
	logic [63:0]       gen_res;
	logic [63:0]       nx [4];
	logic [4:0]        t0, t1, t2, t3;
	logic [63:0]       out_word;

	assign blk   = wn_q[WNUM_W-1:WIDX_W];
	assign widx  = wn_q[WIDX_W-1:0];
	assign is_xo = (mode == MODE_XOSHIRO);

	// Clamp request count and pattern length
	always_comb begin
		if (req.byte_count == 4'd0)      cnt_in = 4'd1;
		else if (req.byte_count > 4'd8)  cnt_in = 4'd8;
		else                             cnt_in = req.byte_count;
		if (pattern_length == 4'd0)                  plen = 4'd1;
		else if (pattern_length > 4'(PATTERN_MAX))   plen = 4'(PATTERN_MAX);
		else                                         plen = pattern_length;
	end

	// Offset modulo pattern length, two bits per step
	always_comb begin
		t0 = {rem_q, off_q[{dig_q, 1'b0} +: 2]};
		t1 = (t0 >= {1'b0, plen}) ? t0 - {1'b0, plen} : t0;
		t2 = (t1 >= {1'b0, plen}) ? t1 - {1'b0, plen} : t1;
		t3 = (t2 >= {1'b0, plen}) ? t2 - {1'b0, plen} : t2;
	end

	// Multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			MS_M1: begin
				mul_a = z_q ^ (z_q >> 30);
				mul_b = MIX1;
			end
			MS_M2: begin
				mul_a = z_q ^ (z_q >> 27);
				mul_b = MIX2;
			end
			default: begin
				mul_a = {3'd0, wn_q};
				mul_b = GOLDEN;
			end
		endcase
	end

	sdg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign mix_res = z_q ^ (z_q >> 31);

	// Generator step
	always_comb begin
		logic [63:0] sum03;
		logic [63:0] n2, n3;
		sum03   = x_q[0] + x_q[3];
		gen_res = {sum03[40:0], sum03[63:41]} + x_q[0];
		n2      = x_q[2] ^ x_q[0];
		n3      = x_q[3] ^ x_q[1];
		nx[1]   = x_q[1] ^ n2;
		nx[0]   = x_q[0] ^ n3;
		nx[2]   = n2 ^ {x_q[1][46:0], 17'd0};
		nx[3]   = {n3[18:0], n3[63:19]};
	end

	// Assemble the result word
	always_comb begin
		logic [2:0]   idx;
		logic [127:0] wide;
		logic [7:0]   b;
		idx  = rem_q;
		wide = {word1_q, word0_q} >> {off_q[2:0], 3'b000};
		out_word = '0;
		for (int i = 0; i < 8; i++) begin
			if (i > 0) begin
				if (off_q == (64'd0 - 64'(i)))            idx = 3'd0;
				else if ({1'b0, idx} + 4'd1 == plen)      idx = 3'd0;
				else                                       idx = idx + 3'd1;
			end
			if (mode == MODE_PATTERN) b = pattern_bytes[{idx, 3'b000} +: 8];
			else                      b = wide[i*8 +: 8];
			if (4'(i) < cnt_q) out_word[i*8 +: 8] = b;
		end
	end

	// Status
	always_comb begin
		sts.mode_pat    = (mode == MODE_PATTERN);
		sts.mode_xo     = is_xo;
		sts.mul_done    = mul_done;
		sts.mod_last    = (dig_q == 5'd0);
		sts.cache_hit   = cval_q && (cblk_q == blk) && (widx > cidx_q);
		sts.seed_last   = (k_q == 2'd3);
		sts.at_target   = (gcnt_q == widx);
		sts.need_second = !slot_q && (({1'b0, off_q[2:0]} + cnt_q) > 4'd8);
		sts.out_full    = rsp_valid_q && rsp_stall;
	end

	// Hold request, mixer and generator registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q  <= req.byte_offset;
			cnt_q  <= cnt_in;
			wn_q   <= req.byte_offset[63:3];
			slot_q <= 1'b0;
			rem_q  <= 3'd0;
			dig_q  <= 5'd31;
		end
		if (cmd.mod_step) begin
			rem_q <= t3[2:0];
			dig_q <= dig_q - 5'd1;
		end
		if (cmd.z_from_prod_seed) z_q <= seed + mul_p;
		if (cmd.z_from_prod)      z_q <= mul_p;
		if (cmd.z_from_s) begin
			z_q <= s_q + GOLDEN;
			s_q <= s_q + GOLDEN;
		end
		if (cmd.seed_init) begin
			s_q    <= seed + 64'(blk);
			k_q    <= 2'd0;
			gcnt_q <= '0;
		end
		if (cmd.gen_setup) gcnt_q <= cidx_q + WIDX_W'(1);
		if (cmd.mix_store) begin
			if (is_xo) begin
				x_q[k_q] <= mix_res;
				k_q      <= k_q + 2'd1;
			end else if (slot_q) begin
				word1_q <= mix_res;
			end else begin
				word0_q <= mix_res;
			end
		end
		if (cmd.gen_step || cmd.gen_take) begin
			for (int j = 0; j < 4; j++) x_q[j] <= nx[j];
		end
		if (cmd.gen_step) gcnt_q <= gcnt_q + WIDX_W'(1);
		if (cmd.gen_take) begin
			if (slot_q) word1_q <= gen_res;
			else        word0_q <= gen_res;
			cblk_q <= blk;
			cidx_q <= widx;
		end
		if (cmd.next_word) begin
			slot_q <= 1'b1;
			wn_q   <= wn_q + WNUM_W'(1);
		end
		if (cmd.finish) begin
			rsp_q.data_word   <= out_word;
			rsp_q.valid_bytes <= cnt_q;
		end
	end

	// Cache flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cval_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cache_inval)       cval_q <= 1'b0;
			else if (cmd.gen_take) cval_q <= 1'b1;
			if (cmd.finish)        rsp_valid_q <= 1'b1;
			else if (!rsp_stall)   rsp_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(rsp_valid_q && rsp_stall)) else $error("result word overwritten");

	a_take_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gen_take |-> gcnt_q == widx) else $error("generator output taken off target");

	a_cache_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gen_take |=> cval_q) else $error("cache not marked after take");

endmodule
`default_nettype wire

// ===== rtl/sdg_ctrl.sv =====
// Controller state machine sequencing the datapath per request.
`default_nettype none
module sdg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sdg_pkg::sts_t sts,
	output sdg_pkg::cmd_t      cmd
);
	import sdg_pkg::*;

	state_t state_q;
	state_t state_nx;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid) begin
				if (sts.mode_pat)     state_nx = ST_MOD;
				else if (sts.mode_xo) state_nx = ST_G_CHECK;
				else                  state_nx = ST_H_GOLD;
			end
			ST_MOD:    if (sts.mod_last) state_nx = ST_FIN;
			ST_H_GOLD: state_nx = ST_H_GW;
			ST_H_GW:   if (sts.mul_done) state_nx = ST_M1;
			ST_M1:     state_nx = ST_M1W;
			ST_M1W:    if (sts.mul_done) state_nx = ST_M2;
			ST_M2:     state_nx = ST_M2W;
			ST_M2W:    if (sts.mul_done) state_nx = ST_MSTORE;
			ST_MSTORE: begin
				if (sts.mode_xo)          state_nx = sts.seed_last ? ST_G_ADV : ST_S_NEXT;
				else if (sts.need_second) state_nx = ST_H_GOLD;
				else                      state_nx = ST_FIN;
			end
			ST_S_NEXT:  state_nx = ST_M1;
			ST_G_CHECK: state_nx = sts.cache_hit ? ST_G_ADV : ST_S_NEXT;
			ST_G_ADV: if (sts.at_target) begin
				state_nx = sts.need_second ? ST_G_CHECK : ST_FIN;
			end
			ST_FIN:  if (!sts.out_full) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MS_GOLD;
		unique case (state_q)
			ST_IDLE:   cmd.load = req_valid;
			ST_MOD:    cmd.mod_step = 1'b1;
			ST_H_GOLD: cmd.mul_start = 1'b1;
			ST_H_GW:   cmd.z_from_prod_seed = sts.mul_done;
			ST_M1: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_M1;
			end
			ST_M1W: cmd.z_from_prod = sts.mul_done;
			ST_M2: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_M2;
			end
			ST_M2W: cmd.z_from_prod = sts.mul_done;
			ST_MSTORE: begin
				cmd.mix_store = 1'b1;
				cmd.next_word = !sts.mode_xo && sts.need_second;
			end
			ST_S_NEXT: cmd.z_from_s = 1'b1;
			ST_G_CHECK: begin
				cmd.gen_setup = sts.cache_hit;
				cmd.seed_init = !sts.cache_hit;
			end
			ST_G_ADV: begin
				cmd.gen_take  = sts.at_target;
				cmd.gen_step  = !sts.at_target;
				cmd.next_word = sts.at_target && sts.need_second;
			end
			ST_FIN:  cmd.finish = !sts.out_full;
			default: cmd = '0;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	assign req_stall = (state_q != ST_IDLE);

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q != ST_IDLE) else $error("request load did not leave idle");

	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_IDLE) else $error("finish did not return to idle");

	a_one_gen_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.gen_step, cmd.gen_take, cmd.gen_setup, cmd.seed_init}) <= 1)
		else $error("conflicting generator commands");

endmodule
`default_nettype wire

// ===== rtl/synthetic_data_generator_core.sv =====
// Top level: register port, controller and datapath of the synthetic data generator.
// Each request runs to rsp_valid through a finish state: pattern mode runs two-bit modulo
// steps over the offset; hash mode does three multiplies and a store per stream word; xoshiro
// steps the held generator on a cache hit, else reseeds it first; a request spans 1 or 2 words.
// One request at a time; req_stall drops in the same cycle that rsp_valid rises; a stalled result waits.
// Reset clears the registers to mode 1, seed 0, pattern 0, length 1, and empties the cache.
`default_nettype none
module synthetic_data_generator_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sdg_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sdg_pkg::rsp_t      rsp,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [63:0]   pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import sdg_pkg::*;

	logic [1:0]  mode_q;
	logic [63:0] seed_q;
	logic [63:0] pat_q;
	logic [3:0]  plen_q;
	logic        wr;
	logic [1:0]  ridx;
	cmd_t        cmd;
	sts_t        sts;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign ridx   = paddr[4:3];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HASH;
			seed_q <= '0;
			pat_q  <= '0;
			plen_q <= 4'd1;
		end else if (wr) begin
			unique case (ridx)
				REG_MODE:    mode_q <= pwdata[1:0];
				REG_SEED:    seed_q <= pwdata;
				REG_PATTERN: pat_q  <= pwdata;
				REG_PLEN:    plen_q <= pwdata[3:0];
				default:     plen_q <= plen_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (ridx)
			REG_MODE:    prdata = {62'd0, mode_q};
			REG_SEED:    prdata = seed_q;
			REG_PATTERN: prdata = pat_q;
			REG_PLEN:    prdata = {60'd0, plen_q};
			default:     prdata = '0;
		endcase
	end

	sdg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sdg_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req            (req),
		.mode           (mode_q),
		.seed           (seed_q),
		.pattern_bytes  (pat_q),
		.pattern_length (plen_q),
		.cache_inval    (wr && (ridx == REG_MODE || ridx == REG_SEED)),
		.rsp            (rsp),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall)
	);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the synthetic data generator core: directed and random requests vs. a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import sdg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// Predictor copy of the registers and the generator cache
	logic [1:0]  cfg_mode;
	logic [63:0] cfg_seed;
	logic [63:0] cfg_pattern;
	logic [3:0]  cfg_plen;
	logic [63:0] xs0, xs1, xs2, xs3;
	logic [63:0] gen_blk;
	logic [12:0] gen_widx;
	logic        gen_held;

	rsp_t        expected_words[$];
	int          errors;
	int          rx_wait;
	int          rx_hold;
	bit          rx_busy;
	bit          tx_busy;

	synthetic_data_generator_core uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] rotl(input logic [63:0] v, input int k);
		return (v << k) | (v >> (64 - k));
	endfunction

	function automatic logic [63:0] mix64(input logic [63:0] z0);
		logic [63:0] z;
		z = (z0 ^ (z0 >> 30)) * MIX1;
		z = (z ^ (z >> 27)) * MIX2;
		return z ^ (z >> 31);
	endfunction

	// Advance the generator one step and return its output
	function logic [63:0] xo_step();
		logic [63:0] res;
		logic [63:0] t;
		res = rotl(xs0 + xs3, 23) + xs0;
		t = xs1 << 17;
		xs2 ^= xs0;
		xs3 ^= xs1;
		xs1 ^= xs2;
		xs0 ^= xs3;
		xs2 ^= t;
		xs3 = rotl(xs3, 45);
		return res;
	endfunction

	function void xo_reseed(input logic [63:0] s0);
		logic [63:0] s;
		s = s0 + GOLDEN;
		xs0 = mix64(s);
		s += GOLDEN;
		xs1 = mix64(s);
		s += GOLDEN;
		xs2 = mix64(s);
		s += GOLDEN;
		xs3 = mix64(s);
	endfunction

	// Word w of block blk, reusing the held generator where it is behind w
	function logic [63:0] xo_block_word(input logic [63:0] blk, input logic [12:0] w);
		int have;
		logic [63:0] v;
		if (gen_held && gen_blk == blk && w > gen_widx) begin
			have = gen_widx + 1;
		end else begin
			xo_reseed(cfg_seed + blk);
			have = 0;
		end
		for (int i = have; i < w; i++)
			v = xo_step();
		v = xo_step();
		gen_blk = blk;
		gen_widx = w;
		gen_held = 1'b1;
		return v;
	endfunction

	function logic [7:0] stream_byte(input logic [63:0] p);
		logic [63:0] len;
		logic [63:0] v;
		if (cfg_mode == MODE_PATTERN) begin
			len = cfg_plen;
			if (len == 0) len = 1;
			if (len > PATTERN_MAX) len = PATTERN_MAX;
			return 8'(cfg_pattern >> ((p % len) * 8));
		end
		if (cfg_mode == MODE_XOSHIRO) begin
			v = xo_block_word(p >> 16, p[15:3]);
			return 8'(v >> (p[2:0] * 8));
		end
		v = mix64(cfg_seed + (p >> 3) * GOLDEN);
		return 8'(v >> (p[2:0] * 8));
	endfunction

	function rsp_t predict_word(input req_t r);
		rsp_t o;
		int cnt;
		cnt = r.byte_count;
		if (cnt == 0) cnt = 1;
		if (cnt > 8) cnt = 8;
		o.data_word = '0;
		for (int i = 0; i < cnt; i++)
			o.data_word |= 64'(stream_byte(r.byte_offset + i)) << (i * 8);
		o.valid_bytes = 4'(cnt);
		return o;
	endfunction

	// Write one register through the APB port and mirror it
	task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE: begin
				cfg_mode = value[1:0];
				gen_held = 1'b0;
			end
			REG_SEED: begin
				cfg_seed = value;
				gen_held = 1'b0;
			end
			REG_PATTERN: cfg_pattern = value;
			REG_PLEN:    cfg_plen = value[3:0];
		endcase
	endtask

	// Send one request word; valid stays high afterwards until the next gap
	task automatic send_word(input logic [63:0] off, input logic [3:0] cnt);
		int gap;
		req_t r;
		gap = tx_busy ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		r.byte_offset = off;
		r.byte_count = cnt;
		req_valid <= 1'b1;
		req <= r;
		expected_words.push_back(predict_word(r));
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Drop valid, drain, then let the block settle before a register write
	task automatic settle();
		req_valid <= 1'b0;
		wait (expected_words.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	// Receiver stall: a long hold-off first, then a fresh draw per word
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rsp_stall <= 1'b1;
			rx_hold--;
		end else if (rx_wait > 0) begin
			rsp_stall <= 1'b1;
			rx_wait--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word data=%h bytes=%0d", $time,
					rsp.data_word, rsp.valid_bytes);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (rsp.data_word !== e.data_word) begin
					$display("%0t: data_word expected %h actual %h", $time,
						e.data_word, rsp.data_word);
					errors++;
				end
				if (rsp.valid_bytes !== e.valid_bytes) begin
					$display("%0t: valid_bytes expected %0d actual %0d", $time,
						e.valid_bytes, rsp.valid_bytes);
					errors++;
				end
			end
			rx_wait = rx_busy ? $urandom_range(0, 3) : 0;
		end
	end

	task automatic test_reset_state();
		send_word(64'd0, 4'd1);
		send_word(64'd5, 4'd0);
		send_word(64'd3, 4'd15);
		send_word(64'd16, 4'd8);
		send_word(64'hFFFF_FFFF_FFFF_FFFD, 4'd8);
		settle();
	endtask

	task automatic test_pattern();
		reg_write(REG_MODE, MODE_PATTERN);
		reg_write(REG_PATTERN, 64'h8877_6655_4433_2211);
		reg_write(REG_PLEN, 4'd0);
		send_word(64'd7, 4'd8);
		settle();
		reg_write(REG_PLEN, 4'd3);
		send_word(64'hFFFF_FFFF_FFFF_FFFE, 4'd8);
		send_word(64'd1, 4'd5);
		settle();
		reg_write(REG_PLEN, 4'd8);
		send_word(64'd6, 4'd8);
		settle();
		reg_write(REG_PLEN, 4'd15);
		reg_write(REG_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(64'h8000_0000_0000_0001, 4'd7);
		settle();
	endtask

	task automatic test_hash();
		reg_write(REG_MODE, MODE_HASH);
		reg_write(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(64'd4, 4'd8);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd2);
		settle();
		reg_write(REG_MODE, MODE_HASH_ALT);
		send_word(64'd12, 4'd8);
		settle();
	endtask

	task automatic test_xoshiro();
		reg_write(REG_MODE, MODE_XOSHIRO);
		reg_write(REG_SEED, 64'h0123_4567_89AB_CDEF);
		send_word(64'd0, 4'd8);
		send_word(64'd8, 4'd8);
		send_word(64'd20, 4'd4);
		send_word(64'd2, 4'd3);
		send_word(64'd65532, 4'd8);
		send_word(64'd65535 * 8, 4'd8);
		send_word(64'hFFFF_FFFF_FFFF_FFFC, 4'd8);
		send_word(64'd65528, 4'd8);
		settle();
	endtask

	// Hold the receiver off while requests keep coming
	task automatic test_backpressure();
		rx_hold = 300;
		for (int i = 0; i < 12; i++)
			send_word(64'd64 + 8 * i, 4'd8);
		settle();
	endtask

	task automatic test_random();
		logic [63:0] off;
		logic [1:0]  m;
		int          cnt;
		for (int ph = 0; ph < 10; ph++) begin
			m = 2'($urandom_range(0, 3));
			reg_write(REG_MODE, m);
			reg_write(REG_SEED, {$urandom, $urandom});
			reg_write(REG_PATTERN, {$urandom, $urandom});
			reg_write(REG_PLEN, $urandom_range(0, 15));
			rx_busy = (ph % 3) != 2;
			tx_busy = (ph % 4) != 3;
			off = {$urandom, $urandom};
			for (int i = 0; i < 200; i++) begin
				cnt = $urandom_range(0, 15);
				if (m != MODE_XOSHIRO) begin
					off = {$urandom, $urandom};
				end else if ($urandom_range(0, 99) == 0) begin
					// deep word inside a block
					off = {$urandom, $urandom};
				end else if ($urandom_range(0, 9) == 0) begin
					// jump to a fresh block near its start
					off = {$urandom, $urandom};
					off[15:0] = 16'($urandom_range(0, 511));
				end else if ($urandom_range(0, 19) == 0) begin
					off = off - $urandom_range(0, 64);
				end
				send_word(off, 4'(cnt));
				if (m == MODE_XOSHIRO)
					off = off + ((cnt == 0) ? 1 : (cnt > 8) ? 8 : cnt);
			end
			settle();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		rx_wait = 0;
		rx_hold = 0;
		rx_busy = 1'b1;
		tx_busy = 1'b1;
		cfg_mode = MODE_HASH;
		cfg_seed = '0;
		cfg_pattern = '0;
		cfg_plen = 4'd1;
		xs0 = '0;
		xs1 = '0;
		xs2 = '0;
		xs3 = '0;
		gen_blk = '0;
		gen_widx = '0;
		gen_held = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_state();
		test_pattern();
		test_hash();
		test_xoshiro();
		test_backpressure();
		test_random();
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("[synthetic_data_generator_core] OK");
		else
			$display("[synthetic_data_generator_core] ERROR");
		$finish;
	end

	// Hard stop on a hang
	initial begin
		#40ms;
		$display("[synthetic_data_generator_core] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== synthetic_data_generator_core.f =====
rtl/sdg_pkg.sv
rtl/sdg_mul.sv
rtl/sdg_datapath.sv
rtl/sdg_ctrl.sv
rtl/synthetic_data_generator_core.sv
tb/testbench.sv
